// ===== src/frs_pkg.sv =====
// shared types, codes and constants of the fair run queue scheduler
`timescale 1ns / 1ps
package frs_pkg;

  localparam int MAX_TASKS_DEF = 64;

  // dividend width of the shared divider: delta shifted by ten, or slice times weight
  localparam int DVD_W = 74;

  localparam logic [29:0] TARGET_LAT_RST = 30'd6000000;
  localparam logic [26:0] MIN_GRAN_RST   = 27'd750000;
  localparam logic [26:0] WAKE_GRAN_RST  = 27'd1000000;

  typedef enum logic [2:0] {
    OP_ENQUEUE  = 3'd0,
    OP_DEQUEUE  = 3'd1,
    OP_PICK     = 3'd2,
    OP_PUT_BACK = 3'd3,
    OP_TICK     = 3'd4,
    OP_CHECK    = 3'd5,
    OP_FORK     = 3'd6,
    OP_YIELD    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  localparam logic [1:0] CFG_TARGET_LAT = 2'd0;
  localparam logic [1:0] CFG_MIN_GRAN   = 2'd1;
  localparam logic [1:0] CFG_WAKE_GRAN  = 2'd2;

  // one task slot as held in the slot memory
  typedef struct packed {
    logic [63:0] vr;
    logic [16:0] wt;
    logic [63:0] sum;
    logic [63:0] prev;
    logic [63:0] start;
    logic [31:0] stamp;
  } entry_t;

endpackage

// ===== src/frs_in_if.sv =====
// request channel of the fair run queue scheduler
`timescale 1ns / 1ps
interface frs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [5:0]  task_req;
  logic [16:0] weight;
  logic        wakeup;
  logic        migrate;
  logic        still_running;
  logic [63:0] now_ns;

  modport source (output valid, op, task_req, weight, wakeup, migrate, still_running, now_ns,
                  input ready);
  modport sink (input valid, op, task_req, weight, wakeup, migrate, still_running, now_ns,
                output ready);
endinterface

// ===== src/frs_out_if.sv =====
// result channel of the fair run queue scheduler
`timescale 1ns / 1ps
interface frs_out_if;
  logic        valid;
  logic        ready;
  logic        picked_valid;
  logic [5:0]  picked_task;
  logic        resched;
  logic [1:0]  status;
  logic [63:0] queue_min_vr;

  modport source (output valid, picked_valid, picked_task, resched, status, queue_min_vr,
                  input ready);
  modport sink (input valid, picked_valid, picked_task, resched, status, queue_min_vr,
                output ready);
endinterface

// ===== src/frs_cfg_if.sv =====
// configuration write channel of the fair run queue scheduler
`timescale 1ns / 1ps
interface frs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [29:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/frs_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module frs_div #(
  parameter int DVD_W = frs_pkg::DVD_W,
  parameter int DVS_W = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] dq;
  logic [DVS_W:0]   sh;
  logic             qbit;

  assign sh   = {rem, dq[DVD_W-1]};
  assign qbit = (sh >= {1'b0, dvs});
  assign quot = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
        rem  <= '0;
        dvs  <= divisor;
        dq   <= dividend;
      end else if (busy) begin
        rem <= qbit ? DVS_W'(sh - {1'b0, dvs}) : sh[DVS_W-1:0];
        dq  <= {dq[DVD_W-2:0], qbit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/fair_runqueue_scheduler.sv =====
// fair run queue scheduler top level: slot memory, sequencer and shared divider
//
//  channel  dir  payload                                              transfer when
//  in_ch    in   op task_req weight wakeup migrate still_running now_ns valid & ready
//  out_ch   out  picked_valid picked_task resched status queue_min_vr   valid & ready
//  cfg      in   index data                                           valid & ready
//
// one request at a time; the slot memory has one read and one write port
// charge of the running task waits on the shared divider, which works through all 74 dividend
// bits; the min update or pick scans all MAX_TASKS slots, and a tick or yield may add a
// slice computation with another divider pass
// sync reset clears flags and counters; slot words read as zero until written
// a finished result waits in the output register; the next request is taken meanwhile
`timescale 1ns / 1ps
module fair_runqueue_scheduler #(
  parameter int MAX_TASKS = frs_pkg::MAX_TASKS_DEF
) (
  input logic       clk,
  input logic       rst,
  frs_in_if.sink    in_ch,
  frs_out_if.source out_ch,
  frs_cfg_if.sink   cfg
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TW_W  = 17 + IDX_W;
  localparam int RG_W  = CNT_W + 27;
  localparam int SL_W  = (RG_W > 30) ? RG_W : 30;
  localparam int PR_W  = SL_W + 17;

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_DISPATCH = 22'h000002,
    S_E0_MOD   = 22'h000004,
    S_CH_ISSUE = 22'h000008,
    S_CH_DATA  = 22'h000010,
    S_CH_DIV   = 22'h000020,
    S_CH_WB    = 22'h000040,
    S_SCAN     = 22'h000080,
    S_POST     = 22'h000100,
    S_D1_DATA  = 22'h000200,
    S_P3_DATA  = 22'h000400,
    S_SLICE    = 22'h000800,
    S_SL_MUL   = 22'h001000,
    S_SL_START = 22'h002000,
    S_SL_DIV   = 22'h004000,
    S_SL_END   = 22'h008000,
    S_P5_CUR   = 22'h010000,
    S_P5_T     = 22'h020000,
    S_FORK     = 22'h040000,
    S_Y_RD     = 22'h080000,
    S_PK_DATA  = 22'h100000,
    S_FINISH   = 22'h200000
  } state_t;

  state_t state;

  // slot memory
  frs_pkg::entry_t mem [MAX_TASKS];
  frs_pkg::entry_t rd_raw, rd_e, mem_wdata;
  logic            rd_ok, mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [MAX_TASKS-1:0] written_q, queued_q, in_tree_q;

  // global state
  logic [63:0]      qmin;
  logic [31:0]      stamp_cnt;
  logic [CNT_W-1:0] runnable;
  logic [TW_W-1:0]  total;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_v;
  logic [29:0]      tgt_lat;
  logic [26:0]      min_gran, wake_gran;

  // request
  frs_pkg::op_t     op_q;
  logic [IDX_W-1:0] t_q;
  logic             ok_q, wake_q, mig_q, still_q;
  logic [16:0]      w_q;
  logic [63:0]      now_q;

  // working registers
  frs_pkg::entry_t  cur_e;
  logic [63:0]      delta_q, charge_q, cv_q, slice_res_q;
  logic [16:0]      tgt_wt_q;
  logic [SL_W-1:0]  slice_q;
  logic [PR_W-1:0]  prod_q;
  logic             scan_pick, scan_ev, best_v;
  logic [IDX_W:0]   scan_idx;
  logic [IDX_W-1:0] scan_ev_idx, best_idx;
  logic [63:0]      best_vr;
  logic [31:0]      best_stamp;

  // result
  logic             res_pv, res_rs;
  logic [IDX_W-1:0] res_pt;
  frs_pkg::status_t res_st;
  logic             o_v, o_pv, o_rs;
  logic [5:0]       o_pt;
  logic [1:0]       o_st;
  logic [63:0]      o_min;

  // divider
  logic                    dv_start, dv_done;
  logic [frs_pkg::DVD_W-1:0] dv_dvd, dv_quot;
  logic [TW_W-1:0]         dv_dvs;

  logic [63:0]     delta_c, pv_vr;
  logic [26:0]     gran;
  logic [RG_W-1:0] rg;
  logic            scan_more, in_xfer;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign out_ch.valid        = o_v;
  assign out_ch.picked_valid = o_pv;
  assign out_ch.picked_task  = o_pt;
  assign out_ch.resched      = o_rs;
  assign out_ch.status       = o_st;
  assign out_ch.queue_min_vr = o_min;

  assign rd_e      = rd_ok ? rd_raw : '0;
  assign delta_c   = (now_q >= rd_e.start) ? now_q - rd_e.start : 64'd0;
  assign gran      = (min_gran == 27'd0) ? 27'd1 : min_gran;
  assign rg        = RG_W'(runnable) * RG_W'(gran);
  assign scan_more = (scan_idx < (IDX_W+1)'(MAX_TASKS));
  assign pv_vr     = rd_e.vr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_raw <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written_q <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (mem_we) written_q[mem_waddr] <= 1'b1;
      rd_ok <= written_q[mem_raddr];
    end
  end

  frs_div #(.DVD_W(frs_pkg::DVD_W), .DVS_W(TW_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dvd),
    .divisor  (dv_dvs),
    .done     (dv_done),
    .quot     (dv_quot)
  );

  always_comb begin
    dv_start = 1'b0;
    dv_dvd   = {delta_c, 10'b0};
    dv_dvs   = TW_W'(rd_e.wt);
    if (state == S_CH_DATA) begin
      dv_start = (rd_e.wt != 17'd0);
    end else if (state == S_SL_START) begin
      dv_start = 1'b1;
      dv_dvd   = frs_pkg::DVD_W'(prod_q);
      dv_dvs   = total;
    end
  end

  // memory port control
  always_comb begin
    frs_pkg::entry_t e;
    e         = rd_e;
    mem_we    = 1'b0;
    mem_waddr = t_q;
    mem_raddr = t_q;
    mem_wdata = rd_e;
    unique case (state)
      S_DISPATCH: begin
        if (op_q == frs_pkg::OP_CHECK || op_q == frs_pkg::OP_YIELD) mem_raddr = cur_idx;
      end
      S_E0_MOD: begin
        if (wake_q) begin
          if (e.vr < qmin) e.vr = qmin;
        end else if (mig_q) begin
          e.vr = e.vr + qmin;
        end
        e.stamp   = stamp_cnt;
        mem_we    = 1'b1;
        mem_wdata = e;
      end
      S_CH_ISSUE: mem_raddr = cur_idx;
      S_CH_WB: begin
        e       = cur_e;
        e.vr    = cur_e.vr + charge_q;
        e.sum   = cur_e.sum + delta_q;
        e.start = now_q;
        mem_we    = 1'b1;
        mem_waddr = cur_idx;
        mem_wdata = e;
      end
      S_SCAN: mem_raddr = scan_more ? scan_idx[IDX_W-1:0] : best_idx;
      S_D1_DATA: begin
        if (mig_q) e.vr = e.vr - qmin;
        mem_we    = 1'b1;
        mem_wdata = e;
      end
      S_P3_DATA: begin
        e.stamp   = stamp_cnt;
        mem_we    = 1'b1;
        mem_wdata = e;
      end
      S_SL_END: begin
        e         = cur_e;
        e.vr      = cur_e.vr + slice_res_q;
        mem_we    = (op_q == frs_pkg::OP_YIELD);
        mem_waddr = cur_idx;
        mem_wdata = e;
      end
      S_FORK: begin
        e.wt      = w_q;
        e.vr      = qmin;
        e.sum     = '0;
        e.prev    = '0;
        e.start   = '0;
        mem_we    = 1'b1;
        mem_wdata = e;
      end
      S_PK_DATA: begin
        e.start   = now_q;
        e.prev    = e.sum;
        mem_we    = 1'b1;
        mem_waddr = best_idx;
        mem_wdata = e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    logic [63:0] v;
    logic        have;
    logic        cq;
    v    = qmin;
    have = 1'b0;
    cq   = queued_q[t_q];
    if (rst) begin
      state     <= S_IDLE;
      queued_q  <= '0;
      in_tree_q <= '0;
      qmin      <= '0;
      stamp_cnt <= '0;
      runnable  <= '0;
      total     <= '0;
      cur_idx   <= '0;
      cur_v     <= 1'b0;
      tgt_lat   <= frs_pkg::TARGET_LAT_RST;
      min_gran  <= frs_pkg::MIN_GRAN_RST;
      wake_gran <= frs_pkg::WAKE_GRAN_RST;
      o_v       <= 1'b0;
      scan_ev   <= 1'b0;
      best_v    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          frs_pkg::CFG_TARGET_LAT: tgt_lat   <= cfg.data;
          frs_pkg::CFG_MIN_GRAN:   min_gran  <= cfg.data[26:0];
          frs_pkg::CFG_WAKE_GRAN:  wake_gran <= cfg.data[26:0];
          default: ;
        endcase
      end
      // finish reloads the output register itself
      if (o_v && out_ch.ready && state != S_FINISH) o_v <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op_q    <= frs_pkg::op_t'(in_ch.op);
            ok_q    <= (32'(in_ch.task_req) < MAX_TASKS);
            t_q     <= (32'(in_ch.task_req) < MAX_TASKS) ? IDX_W'(in_ch.task_req) : '0;
            w_q     <= in_ch.weight;
            wake_q  <= in_ch.wakeup;
            mig_q   <= in_ch.migrate;
            still_q <= in_ch.still_running;
            now_q   <= in_ch.now_ns;
            res_pv  <= 1'b0;
            res_pt  <= '0;
            res_rs  <= 1'b0;
            res_st  <= frs_pkg::ST_DONE;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (op_q)
            frs_pkg::OP_ENQUEUE:
              if (!ok_q || cq) begin
                res_st <= frs_pkg::ST_IGNORED;
                state  <= S_FINISH;
              end else state <= S_E0_MOD;
            frs_pkg::OP_DEQUEUE:
              if (!ok_q || !cq) begin
                res_st <= frs_pkg::ST_IGNORED;
                state  <= S_FINISH;
              end else state <= cur_v ? S_CH_ISSUE : S_POST;
            frs_pkg::OP_PICK: begin
              scan_pick <= 1'b1;
              scan_idx  <= '0;
              scan_ev   <= 1'b0;
              best_v    <= 1'b0;
              state     <= S_SCAN;
            end
            frs_pkg::OP_PUT_BACK:
              if (!ok_q) begin
                res_st <= frs_pkg::ST_IGNORED;
                state  <= S_FINISH;
              end else if (!still_q) state <= S_FINISH;
              else if (!cq || in_tree_q[t_q]) begin
                res_st <= frs_pkg::ST_IGNORED;
                state  <= S_FINISH;
              end else state <= cur_v ? S_CH_ISSUE : S_POST;
            frs_pkg::OP_TICK:
              if (!cur_v) begin
                res_st <= frs_pkg::ST_IGNORED;
                state  <= S_FINISH;
              end else state <= S_CH_ISSUE;
            frs_pkg::OP_CHECK:
              if (!ok_q || !cur_v) begin
                res_st <= frs_pkg::ST_IGNORED;
                state  <= S_FINISH;
              end else state <= S_P5_CUR;
            frs_pkg::OP_FORK:
              if (!ok_q || cq) begin
                res_st <= frs_pkg::ST_IGNORED;
                state  <= S_FINISH;
              end else state <= S_FORK;
            default:
              if (!cur_v) begin
                res_st <= frs_pkg::ST_IGNORED;
                state  <= S_FINISH;
              end else state <= S_Y_RD;
          endcase
        end
        S_E0_MOD: begin
          tgt_wt_q <= rd_e.wt;
          state    <= cur_v ? S_CH_ISSUE : S_POST;
        end
        S_CH_ISSUE: state <= S_CH_DATA;
        S_CH_DATA: begin
          cur_e    <= rd_e;
          delta_q  <= delta_c;
          charge_q <= delta_c;
          state    <= (rd_e.wt == 17'd0) ? S_CH_WB : S_CH_DIV;
        end
        S_CH_DIV: begin
          if (dv_done) begin
            charge_q <= dv_quot[63:0];
            state    <= S_CH_WB;
          end
        end
        S_CH_WB: begin
          cur_e.vr  <= cur_e.vr + charge_q;
          cur_e.sum <= cur_e.sum + delta_q;
          scan_pick <= 1'b0;
          scan_idx  <= '0;
          scan_ev   <= 1'b0;
          best_v    <= 1'b0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_ev && in_tree_q[scan_ev_idx] &&
              (!best_v || rd_e.vr < best_vr ||
               (rd_e.vr == best_vr && rd_e.stamp < best_stamp))) begin
            best_v     <= 1'b1;
            best_idx   <= scan_ev_idx;
            best_vr    <= rd_e.vr;
            best_stamp <= rd_e.stamp;
          end
          if (scan_more) begin
            scan_ev     <= 1'b1;
            scan_ev_idx <= scan_idx[IDX_W-1:0];
            scan_idx    <= scan_idx + (IDX_W+1)'(1);
          end else begin
            scan_ev <= 1'b0;
          end
          if (!scan_more && !scan_ev) begin
            if (scan_pick) begin
              if (!best_v) begin
                res_st <= frs_pkg::ST_EMPTY;
                state  <= S_FINISH;
              end else begin
                state <= S_PK_DATA;
              end
            end else begin
              // minimum follows the lesser of running task and leftmost, never backward
              if (cur_v && queued_q[cur_idx]) begin
                v    = cur_e.vr;
                have = 1'b1;
              end
              if (best_v && (!have || best_vr < v)) v = best_vr;
              if (v > qmin) qmin <= v;
              state <= S_POST;
            end
          end
        end
        S_POST: begin
          case (op_q)
            frs_pkg::OP_ENQUEUE: begin
              queued_q[t_q]  <= 1'b1;
              in_tree_q[t_q] <= 1'b1;
              stamp_cnt      <= stamp_cnt + 32'd1;
              runnable       <= runnable + CNT_W'(1);
              total          <= total + TW_W'(tgt_wt_q);
              state          <= S_FINISH;
            end
            frs_pkg::OP_DEQUEUE:  state <= S_D1_DATA;
            frs_pkg::OP_PUT_BACK: state <= S_P3_DATA;
            frs_pkg::OP_TICK:     state <= (runnable > CNT_W'(1)) ? S_SLICE : S_FINISH;
            default:              state <= S_FINISH;
          endcase
        end
        S_D1_DATA: begin
          queued_q[t_q]  <= 1'b0;
          in_tree_q[t_q] <= 1'b0;
          if (runnable != '0) runnable <= runnable - CNT_W'(1);
          total <= (total >= TW_W'(rd_e.wt)) ? total - TW_W'(rd_e.wt) : '0;
          state <= S_FINISH;
        end
        S_P3_DATA: begin
          in_tree_q[t_q] <= 1'b1;
          stamp_cnt      <= stamp_cnt + 32'd1;
          state          <= S_FINISH;
        end
        S_SLICE: begin
          // runnable > latency / gran is the same test as runnable * gran > latency
          slice_q <= (rg > RG_W'(tgt_lat)) ? SL_W'(rg) : SL_W'(tgt_lat);
          state   <= S_SL_MUL;
        end
        S_SL_MUL: begin
          if (total == '0) begin
            slice_res_q <= 64'(slice_q);
            state       <= S_SL_END;
          end else begin
            prod_q <= PR_W'(slice_q) * PR_W'(cur_e.wt);
            state  <= S_SL_START;
          end
        end
        S_SL_START: state <= S_SL_DIV;
        S_SL_DIV: begin
          if (dv_done) begin
            slice_res_q <= dv_quot[63:0];
            state       <= S_SL_END;
          end
        end
        S_SL_END: begin
          if (op_q == frs_pkg::OP_TICK) res_rs <= ((cur_e.sum - cur_e.prev) > slice_res_q);
          state <= S_FINISH;
        end
        S_P5_CUR: begin
          cv_q  <= rd_e.vr;
          state <= S_P5_T;
        end
        S_P5_T: begin
          res_rs <= (cv_q > pv_vr) && ((cv_q - pv_vr) > 64'(wake_gran));
          state  <= S_FINISH;
        end
        S_FORK: state <= S_FINISH;
        S_Y_RD: begin
          cur_e <= rd_e;
          state <= S_SLICE;
        end
        S_PK_DATA: begin
          in_tree_q[best_idx] <= 1'b0;
          cur_idx <= best_idx;
          cur_v   <= 1'b1;
          res_pv  <= 1'b1;
          res_pt  <= best_idx;
          state   <= S_FINISH;
        end
        S_FINISH: begin
          if (!o_v || out_ch.ready) begin
            o_v   <= 1'b1;
            o_pv  <= res_pv;
            o_pt  <= 6'(res_pt);
            o_rs  <= res_rs;
            o_st  <= res_st;
            o_min <= qmin;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_tree_queued: assert property (@(posedge clk) disable iff (rst)
    (in_tree_q & ~queued_q) == '0)
    else $error("slot in tree without being queued");

  a_runnable_max: assert property (@(posedge clk) disable iff (rst)
    runnable <= CNT_W'(MAX_TASKS))
    else $error("runnable count above slot count");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == S_CH_DIV || state == S_SL_DIV))
    else $error("divider finished outside a wait state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_DISPATCH))
    else $error("accepted request not dispatched");

  a_qmin_monotone: assert property (@(posedge clk) disable iff (rst)
    !$rose(rst) |=> (qmin >= $past(qmin)) || $past(rst))
    else $error("queue minimum went backward");

endmodule
